FILE: hdl/abkf_pkg.sv
`timescale 1ns / 1ps
package abkf_pkg;
    // sequencer operation codes
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_DIV = 2'd1;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } abkf_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } abkf_stat_t;

    localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;
    localparam logic [1:0] REG_TIME_STEP     = 2'd3;
endpackage

FILE: hdl/abkf_arith.sv
`timescale 1ns / 1ps
// shared unit: signed fixed-point multiply (result registered in the cycle after start)
// and restoring divide (one quotient bit per cycle)
module abkf_arith #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  abkf_pkg::abkf_cmd_t           cmd,
    input  logic signed [DATA_WIDTH-1:0]  op_a,
    input  logic signed [DATA_WIDTH:0]    op_b,
    output abkf_pkg::abkf_stat_t          stat,
    output logic signed [DATA_WIDTH-1:0]  result
);
    localparam int QW = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);
    localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             neg_reg, neg_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [QW-1:0]    num_reg, num_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [DATA_WIDTH:0] rem_reg, rem_next;
    logic [DATA_WIDTH:0] den_reg, den_next;
    logic signed [DATA_WIDTH-1:0] res_reg, res_next;

    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [2*DATA_WIDTH-1:0] prod;
    logic [2*DATA_WIDTH-1:0] rnd;
    logic [2*DATA_WIDTH-1:0] shifted;
    logic                    m_neg;
    logic [DATA_WIDTH+1:0]   rem_sh;
    logic [DATA_WIDTH+1:0]   rem_sub;

    function automatic logic signed [DATA_WIDTH-1:0] from_mag(
        input logic [2*DATA_WIDTH-1:0] m, input logic n);
        logic [2*DATA_WIDTH-1:0] lim;
        lim = {{DATA_WIDTH{1'b0}}, 1'b0, {(DATA_WIDTH-1){1'b1}}};
        if (n) begin
            if (m > lim) from_mag = MINV;
            else from_mag = -$signed(m[DATA_WIDTH-1:0]);
        end
        else begin
            if (m > lim) from_mag = MAXV;
            else from_mag = m[DATA_WIDTH-1:0];
        end
    endfunction

    always_comb
    begin
        mag_a   = op_a[DATA_WIDTH-1] ? -op_a : op_a;
        mag_b   = op_b[DATA_WIDTH-1] ? -op_b[DATA_WIDTH-1:0] : op_b[DATA_WIDTH-1:0];
        m_neg   = op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
        prod    = mag_a * mag_b;
        rnd     = prod + ((2*DATA_WIDTH)'(1) << (FRAC_BITS - 1));
        shifted = rnd >> FRAC_BITS;
        rem_sh  = {rem_reg, num_reg[QW-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        res_next  = res_reg;
        if (cmd.start && !busy_reg) begin
            case (cmd.op)
                abkf_pkg::OP_MUL:
                begin
                    res_next  = from_mag(shifted, m_neg);
                    done_next = 1'b1;
                end
                abkf_pkg::OP_DIV:
                begin
                    busy_next = 1'b1;
                    neg_next  = op_a[DATA_WIDTH-1];
                    num_next  = QW'(mag_a) << FRAC_BITS;
                    den_next  = op_b;
                    rem_next  = '0;
                    quo_next  = '0;
                    cnt_next  = CW'(QW);
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg) begin
            num_next = num_reg << 1;
            if (!rem_sub[DATA_WIDTH+1]) begin
                rem_next = rem_sub[DATA_WIDTH:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else begin
                rem_next = rem_sh[DATA_WIDTH:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = from_mag((2*DATA_WIDTH)'(quo_next), neg_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        res_reg <= res_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == CW'(1)) |=> done_reg) else $error("divide end lost");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0)) else $error("divide count underflow");
endmodule

FILE: hdl/angle_bias_kalman_filter.sv
`timescale 1ns / 1ps
// One axis of a two-state angle/gyro-bias Kalman filter in signed fixed point
// (FRAC_BITS fraction bits, DATA_WIDTH-bit state). Each item carries the
// accelerometer angle and gyro rate; the filter predicts, propagates the 2x2
// covariance, forms the gains by division by the innovation variance and
// returns one item with the new angle and bias, saturated to 32 bits. When
// the innovation variance is not positive, the gain and correction steps are
// skipped and the predicted state is returned. All multiplies and divides go
// through one shared multiply/divide unit under a step sequencer: a multiply
// result is registered in the cycle after its start, a divide produces one
// quotient bit per cycle and then flags done. An item takes 10 multiplies and
// 2 divides, or 4 multiplies and no divide when the variance is not positive.
// The block takes one item at a time and accepts the next input the cycle
// after the result is taken, so it cannot take a new item before it is
// through with the last. Configuration writes are taken only while idle and
// use cfg_index per register list order (angle_noise, bias_noise,
// measure_noise, time_step); other indexes are ignored.
module angle_bias_kalman_filter #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] measured_angle,
    input  logic signed [31:0] measured_rate,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] filtered_angle,
    output logic signed [31:0] estimated_bias,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    localparam int W = DATA_WIDTH;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // sequencer steps
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RATE  = 5'd1;   // rate = mr - bias; start dt*rate
    localparam logic [4:0] S_ANG   = 5'd2;   // angle += ; start dt*cov_bb
    localparam logic [4:0] S_DP    = 5'd3;   // dp; t; start dt*t
    localparam logic [4:0] S_PAA   = 5'd4;   // cov_aa +=, ab/ba -= dp; start bn*dt
    localparam logic [4:0] S_PBB   = 5'd5;   // cov_bb +=; test s; start div aa/s
    localparam logic [4:0] S_K0    = 5'd6;   // k0; start div ba/s
    localparam logic [4:0] S_K1    = 5'd7;   // k1; y; start k0*y
    localparam logic [4:0] S_CANG  = 5'd8;   // angle +=; start k1*y
    localparam logic [4:0] S_CBIAS = 5'd9;   // bias +=; start k0*p00
    localparam logic [4:0] S_CAA   = 5'd10;  // start k0*p01
    localparam logic [4:0] S_CAB   = 5'd11;  // start k1*p00
    localparam logic [4:0] S_CBA   = 5'd12;  // start k1*p01
    localparam logic [4:0] S_CBB   = 5'd13;  // finish
    localparam logic [4:0] S_OUT   = 5'd14;

    logic [4:0] state_reg, state_next;
    logic       wait_reg, wait_next;   // waiting on the shared unit

    logic [15:0] angle_noise_reg, bias_noise_reg, time_step_reg;
    logic [23:0] measure_noise_reg;

    logic signed [W-1:0] ang_reg, ang_next, bias_reg, bias_next;
    logic signed [W-1:0] paa_reg, paa_next, pab_reg, pab_next;
    logic signed [W-1:0] pba_reg, pba_next, pbb_reg, pbb_next;
    logic signed [W-1:0] ma_reg, ma_next, tmp_reg, tmp_next; // rate/dp/y
    logic signed [W-1:0] k0_reg, k0_next, k1_reg, k1_next;
    logic signed [W-1:0] p00_reg, p00_next, p01_reg, p01_next;
    logic signed [W:0]   s_reg, s_next;
    logic signed [31:0]  oa_reg, oa_next, ob_reg, ob_next;

    abkf_pkg::abkf_cmd_t  cmd;
    abkf_pkg::abkf_stat_t stat;
    logic signed [W-1:0]  op_a;
    logic signed [W:0]    op_b;
    logic signed [W-1:0]  res;
    logic                 ready_step;

    function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] v);
        if (v > $signed({{2{1'b0}}, MAXV})) sat = MAXV;
        else if (v < $signed({{2{1'b1}}, MINV})) sat = MINV;
        else sat = v[W-1:0];
    endfunction

    function automatic logic signed [W+1:0] ext(input logic signed [W-1:0] v);
        ext = {{2{v[W-1]}}, v};
    endfunction

    function automatic logic signed [W-1:0] in_sat(input logic signed [31:0] v);
        logic signed [63:0] x;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        x  = 64'(v);
        hi = 64'(MAXV);
        lo = 64'(MINV);
        if (x > hi) in_sat = MAXV;
        else if (x < lo) in_sat = MINV;
        else in_sat = x[W-1:0];
    endfunction

    function automatic logic signed [31:0] out_sat(input logic signed [W-1:0] v);
        logic signed [63:0] x;
        x = 64'(v);
        if (x > 64'sd2147483647) out_sat = 32'sh7fffffff;
        else if (x < -64'sd2147483648) out_sat = 32'sh80000000;
        else out_sat = x[31:0];
    endfunction

    abkf_arith #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(W)) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .op_a   (op_a),
        .op_b   (op_b),
        .stat   (stat),
        .result (res)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign cfg_ready = (state_reg == S_IDLE);
    assign filtered_angle = oa_reg;
    assign estimated_bias = ob_reg;

    // a step advances when nothing is pending or the unit just finished
    assign ready_step = !wait_reg || stat.done;

    always_comb
    begin
        logic signed [W-1:0] dt;
        logic signed [W-1:0] t;
        logic signed [W:0]   sv;
        dt = W'(time_step_reg);
        t  = '0;
        sv = '0;
        state_next = state_reg;
        wait_next  = wait_reg;
        ang_next = ang_reg;   bias_next = bias_reg;
        paa_next = paa_reg;   pab_next = pab_reg;
        pba_next = pba_reg;   pbb_next = pbb_reg;
        ma_next  = ma_reg;    tmp_next = tmp_reg;
        k0_next  = k0_reg;    k1_next  = k1_reg;
        p00_next = p00_reg;   p01_next = p01_reg;
        s_next   = s_reg;
        oa_next  = oa_reg;    ob_next  = ob_reg;
        cmd.start = 1'b0;
        cmd.op    = abkf_pkg::OP_MUL;
        op_a = '0;
        op_b = '0;
        if (wait_reg && stat.done) wait_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    ma_next  = in_sat(measured_angle);
                    tmp_next = sat(ext(in_sat(measured_rate)) - ext(bias_reg));
                    state_next = S_RATE;
                end
            end
            S_RATE:
            begin
                cmd.start = 1'b1; op_a = dt; op_b = {tmp_reg[W-1], tmp_reg};
                wait_next = 1'b1; state_next = S_ANG;
            end
            S_ANG:
            begin
                if (ready_step) begin
                    ang_next = sat(ext(ang_reg) + ext(res));
                    cmd.start = 1'b1; op_a = dt; op_b = {pbb_reg[W-1], pbb_reg};
                    wait_next = 1'b1; state_next = S_DP;
                end
            end
            S_DP:
            begin
                if (ready_step) begin
                    tmp_next = res;
                    t = sat(ext(res) - ext(pab_reg) - ext(pba_reg)
                            + (W+2)'(angle_noise_reg));
                    cmd.start = 1'b1; op_a = dt; op_b = {t[W-1], t};
                    wait_next = 1'b1; state_next = S_PAA;
                end
            end
            S_PAA:
            begin
                if (ready_step) begin
                    paa_next = sat(ext(paa_reg) + ext(res));
                    pab_next = sat(ext(pab_reg) - ext(tmp_reg));
                    pba_next = sat(ext(pba_reg) - ext(tmp_reg));
                    cmd.start = 1'b1; op_a = W'(bias_noise_reg); op_b = {dt[W-1], dt};
                    wait_next = 1'b1; state_next = S_PBB;
                end
            end
            S_PBB:
            begin
                if (ready_step) begin
                    pbb_next = sat(ext(pbb_reg) + ext(res));
                    sv = {paa_reg[W-1], paa_reg} + (W+1)'(measure_noise_reg);
                    s_next = sv;
                    if (sv > 0) begin
                        cmd.start = 1'b1; cmd.op = abkf_pkg::OP_DIV;
                        op_a = paa_reg; op_b = sv;
                        wait_next = 1'b1; state_next = S_K0;
                    end
                    else begin
                        state_next = S_CBB;
                    end
                end
            end
            S_K0:
            begin
                if (ready_step) begin
                    k0_next = res;
                    cmd.start = 1'b1; cmd.op = abkf_pkg::OP_DIV;
                    op_a = pba_reg; op_b = s_reg;
                    wait_next = 1'b1; state_next = S_K1;
                end
            end
            S_K1:
            begin
                if (ready_step) begin
                    k1_next  = res;
                    t = sat(ext(ma_reg) - ext(ang_reg));
                    tmp_next = t;
                    p00_next = paa_reg;
                    p01_next = pab_reg;
                    cmd.start = 1'b1; op_a = k0_reg; op_b = {t[W-1], t};
                    wait_next = 1'b1; state_next = S_CANG;
                end
            end
            S_CANG:
            begin
                if (ready_step) begin
                    ang_next = sat(ext(ang_reg) + ext(res));
                    cmd.start = 1'b1; op_a = k1_reg; op_b = {tmp_reg[W-1], tmp_reg};
                    wait_next = 1'b1; state_next = S_CBIAS;
                end
            end
            S_CBIAS:
            begin
                if (ready_step) begin
                    bias_next = sat(ext(bias_reg) + ext(res));
                    cmd.start = 1'b1; op_a = k0_reg; op_b = {p00_reg[W-1], p00_reg};
                    wait_next = 1'b1; state_next = S_CAA;
                end
            end
            S_CAA:
            begin
                if (ready_step) begin
                    paa_next = sat(ext(paa_reg) - ext(res));
                    cmd.start = 1'b1; op_a = k0_reg; op_b = {p01_reg[W-1], p01_reg};
                    wait_next = 1'b1; state_next = S_CAB;
                end
            end
            S_CAB:
            begin
                if (ready_step) begin
                    pab_next = sat(ext(pab_reg) - ext(res));
                    cmd.start = 1'b1; op_a = k1_reg; op_b = {p00_reg[W-1], p00_reg};
                    wait_next = 1'b1; state_next = S_CBA;
                end
            end
            S_CBA:
            begin
                if (ready_step) begin
                    pba_next = sat(ext(pba_reg) - ext(res));
                    cmd.start = 1'b1; op_a = k1_reg; op_b = {p01_reg[W-1], p01_reg};
                    wait_next = 1'b1; state_next = S_CBB;
                end
            end
            S_CBB:
            begin
                if (ready_step) begin
                    if (wait_reg) pbb_next = sat(ext(pbb_reg) - ext(res));
                    oa_next = out_sat(ang_reg);
                    ob_next = out_sat(bias_reg);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready) state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
                wait_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            angle_noise_reg   <= 16'd66;
            bias_noise_reg    <= 16'd197;
            measure_noise_reg <= 24'd1966;
            time_step_reg     <= 16'd262;
            ang_reg  <= '0;
            bias_reg <= '0;
            paa_reg  <= '0;
            pab_reg  <= '0;
            pba_reg  <= '0;
            pbb_reg  <= '0;
        end
        else begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            ang_reg  <= ang_next;
            bias_reg <= bias_next;
            paa_reg  <= paa_next;
            pab_reg  <= pab_next;
            pba_reg  <= pba_next;
            pbb_reg  <= pbb_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    abkf_pkg::REG_ANGLE_NOISE:   angle_noise_reg   <= cfg_data[15:0];
                    abkf_pkg::REG_BIAS_NOISE:    bias_noise_reg    <= cfg_data[15:0];
                    abkf_pkg::REG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                    abkf_pkg::REG_TIME_STEP:     time_step_reg     <= cfg_data[15:0];
                    default:                     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        tmp_reg <= tmp_next;
        k0_reg  <= k0_next;
        k1_reg  <= k1_next;
        p00_reg <= p00_next;
        p01_reg <= p01_next;
        s_reg   <= s_next;
        oa_reg  <= oa_next;
        ob_reg  <= ob_next;
    end

    // a new operation is only started when the unit is free
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !stat.busy) else $error("start while unit busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(filtered_angle)))
        else $error("result dropped");
    a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !wait_reg) else $error("idle with pending operation");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
endmodule

FILE: dv/tb_angle_bias_kalman_filter.sv
`timescale 1ns / 1ps
module tb_angle_bias_kalman_filter;

    // data path limits at the default widths
    localparam longint FX_MAX = 64'sd2147483647;
    localparam longint FX_MIN = -64'sd2147483648;
    localparam int     N_PHASES = 6;
    localparam int     ITEMS_PER_PHASE = 150;

    // idle modes for sender and receiver
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] bias;
    } estimate_t;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
        bit                 typed;      // expected value typed in below
        logic signed [31:0] exp_angle;
        logic signed [31:0] exp_bias;
    } sensor_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] filtered_angle;
    logic signed [31:0] estimated_bias;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;

    angle_bias_kalman_filter u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .measured_angle (measured_angle),
        .measured_rate  (measured_rate),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_angle (filtered_angle),
        .estimated_bias (estimated_bias),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // filter copy: registers and state
    longint     q_angle_noise, q_bias_noise, q_measure_noise, q_time_step;
    longint     st_angle, st_bias, p_aa, p_ab, p_ba, p_bb;
    estimate_t  estimate_q[$];
    idle_mode_t idle_mode;
    int         mismatches;
    int         items_sent;
    int         results_seen;
    int         no_gain_steps;   // steps with nonpositive innovation variance

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // clamp to the signed 32-bit data path
    function automatic longint clamp(longint v);
        if (v > FX_MAX) return FX_MAX;
        if (v < FX_MIN) return FX_MIN;
        return v;
    endfunction

    function automatic logic [127:0] magnitude(longint v);
        logic [63:0] u;
        u = (v < 0) ? -v : v;
        return {64'd0, u};
    endfunction

    // signed result from a magnitude, saturating
    function automatic longint signed_of(logic [127:0] m, bit neg);
        if (neg) begin
            if (m > 128'd2147483648) return FX_MIN;
            return -longint'(m[63:0]);
        end
        if (m > 128'd2147483647) return FX_MAX;
        return longint'(m[63:0]);
    endfunction

    // fixed-point product, round half away from zero
    function automatic longint fx_product(longint a, longint b);
        logic [127:0] m;
        m = magnitude(a) * magnitude(b);
        m = (m + 128'd32768) >> 16;
        return signed_of(m, (a < 0) != (b < 0));
    endfunction

    // fixed-point quotient, truncated toward zero, d positive
    function automatic longint fx_quotient(longint n, longint d);
        logic [127:0] m;
        m = (magnitude(n) << 16) / magnitude(d);
        return signed_of(m, n < 0);
    endfunction

    // one filter update: predict, then correct when the variance is positive
    function automatic estimate_t kalman_update(longint ma, longint mr);
        longint    rate, t, dp, s, k0, k1, y, p00, p01;
        estimate_t r;
        rate = clamp(mr - st_bias);
        st_angle = clamp(st_angle + fx_product(q_time_step, rate));
        dp = fx_product(q_time_step, p_bb);
        t = clamp(dp - p_ab - p_ba + q_angle_noise);
        p_aa = clamp(p_aa + fx_product(q_time_step, t));
        p_ab = clamp(p_ab - dp);
        p_ba = clamp(p_ba - dp);
        p_bb = clamp(p_bb + fx_product(q_bias_noise, q_time_step));
        s = p_aa + q_measure_noise;
        if (s > 0) begin
            k0 = fx_quotient(p_aa, s);
            k1 = fx_quotient(p_ba, s);
            y = clamp(ma - st_angle);
            st_angle = clamp(st_angle + fx_product(k0, y));
            st_bias = clamp(st_bias + fx_product(k1, y));
            p00 = p_aa;
            p01 = p_ab;
            p_aa = clamp(p_aa - fx_product(k0, p00));
            p_ab = clamp(p_ab - fx_product(k0, p01));
            p_ba = clamp(p_ba - fx_product(k1, p00));
            p_bb = clamp(p_bb - fx_product(k1, p01));
        end else begin
            no_gain_steps++;
        end
        r.angle = st_angle[31:0];
        r.bias = st_bias[31:0];
        return r;
    endfunction

    // receiver: stalls depend on the current idle mode
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: out_ready <= ($urandom_range(99) >= 84);
                IDLE_BOTH:     out_ready <= ($urandom_range(99) >= 18);
                default:       out_ready <= 1'b1;
            endcase
        end
    end

    // result checker: oldest expectation first
    always @(posedge clk) begin
        estimate_t e;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (estimate_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: angle %0d bias %0d",
                             filtered_angle, estimated_bias);
            end else begin
                e = estimate_q.pop_front();
                if (filtered_angle !== e.angle || estimated_bias !== e.bias) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch item %0d: angle exp %0d got %0d, bias exp %0d got %0d",
                                 results_seen, e.angle, filtered_angle,
                                 e.bias, estimated_bias);
                end
            end
        end
    end

    // wait for every expected item, then let the block settle
    task automatic drain_results();
        while (estimate_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            abkf_pkg::REG_ANGLE_NOISE:   q_angle_noise   = value[15:0];
            abkf_pkg::REG_BIAS_NOISE:    q_bias_noise    = value[15:0];
            abkf_pkg::REG_MEASURE_NOISE: q_measure_noise = value;
            default:                     q_time_step     = value[15:0];
        endcase
    endtask

    // send one sensor item, optional gap first, and record its expectation
    task automatic send_sample(logic signed [31:0] ma, logic signed [31:0] mr,
                               output estimate_t res);
        bit idle_now;
        idle_now = (idle_mode == IDLE_SENDER) ? ($urandom_range(99) < 84) :
                   (idle_mode == IDLE_BOTH)   ? ($urandom_range(99) < 18) : 1'b0;
        if (idle_now) begin
            in_valid <= 1'b0;
            do @(posedge clk);
            while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 84) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(99) < 18));
        end
        in_valid       <= 1'b1;
        measured_angle <= ma;
        measured_rate  <= mr;
        do @(posedge clk); while (!in_ready);
        res = kalman_update(longint'(ma), longint'(mr));
        estimate_q.push_back(res);
        items_sent++;
    endtask

    // directed items: extremes of both fields and typical values around the reset settings
    sensor_row_t directed[] = '{
        '{32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0},   // from reset nothing moves
        '{32'sh7fffffff, 32'sd0, 1'b0, 32'sd0, 32'sd0},
        '{32'sh80000000, 32'sd0, 1'b0, 32'sd0, 32'sd0},
        '{32'sd0, 32'sh7fffffff, 1'b0, 32'sd0, 32'sd0},
        '{32'sd0, 32'sh80000000, 1'b0, 32'sd0, 32'sd0},
        '{32'sh7fffffff, 32'sh7fffffff, 1'b0, 32'sd0, 32'sd0},
        '{32'sh80000000, 32'sh80000000, 1'b0, 32'sd0, 32'sd0},
        '{32'sh7fffffff, 32'sh80000000, 1'b0, 32'sd0, 32'sd0},
        '{32'sh80000000, 32'sh7fffffff, 1'b0, 32'sd0, 32'sd0},
        '{32'sd655360, 32'sd65536, 1'b0, 32'sd0, 32'sd0},      // 10 deg, 1 dps
        '{-32'sd655360, -32'sd65536, 1'b0, 32'sd0, 32'sd0},
        '{32'sd1, -32'sd1, 1'b0, 32'sd0, 32'sd0},
        '{32'shaaaaaaaa, 32'sh55555555, 1'b0, 32'sd0, 32'sd0},
        '{32'sh55555555, 32'shaaaaaaaa, 1'b0, 32'sd0, 32'sd0},
        '{32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0}
    };

    // register sets per phase: nominal, low extremes, high extremes,
    // zero measurement noise, two random sets
    function automatic logic [23:0] phase_reg(int phase, logic [1:0] idx);
        case (phase)
            0: return (idx == abkf_pkg::REG_MEASURE_NOISE) ? 24'd1966 :
                      (idx == abkf_pkg::REG_TIME_STEP) ? 24'd262 :
                      (idx == abkf_pkg::REG_ANGLE_NOISE) ? 24'd66 : 24'd197;
            1: return (idx == abkf_pkg::REG_MEASURE_NOISE ||
                       idx == abkf_pkg::REG_TIME_STEP) ? 24'd1 : 24'd0;
            2: return (idx == abkf_pkg::REG_MEASURE_NOISE) ? 24'hffffff : 24'hffff;
            3: return (idx == abkf_pkg::REG_MEASURE_NOISE) ? 24'd0 :
                      (idx == abkf_pkg::REG_TIME_STEP) ? 24'd655 : 24'd0;
            default: return (idx == abkf_pkg::REG_MEASURE_NOISE) ?
                            24'($urandom_range(200000, 1)) :
                            24'($urandom_range(65535));
        endcase
    endfunction

    // stimulus
    initial begin
        estimate_t          res;
        logic signed [31:0] ma, mr;
        int                 phase, k, sel, i;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        measured_angle = '0;
        measured_rate  = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        idle_mode      = IDLE_NONE;
        mismatches     = 0;
        items_sent     = 0;
        results_seen   = 0;
        no_gain_steps  = 0;
        q_angle_noise   = 66;
        q_bias_noise    = 197;
        q_measure_noise = 1966;
        q_time_step     = 262;
        st_angle = 0; st_bias = 0;
        p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the reset settings
        foreach (directed[r]) begin
            send_sample(directed[r].angle, directed[r].rate, res);
            if (directed[r].typed &&
                (res.angle !== directed[r].exp_angle || res.bias !== directed[r].exp_bias)) begin
                mismatches++;
                $display("directed row %0d: model disagrees with typed value", r);
            end
        end
        in_valid <= 1'b0;

        // random phases, each with its own registers and idle mode
        for (phase = 0; phase < N_PHASES; phase++) begin
            drain_results();
            for (i = 0; i < 4; i++)
                write_reg(2'(i), phase_reg(phase, 2'(i)));
            idle_mode = idle_mode_t'(phase % 4);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // hold off once until the block is empty
                if (phase == 1 && k == 40) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (estimate_q.size() != 0)
                        @(posedge clk);
                end
                sel = $urandom_range(99);
                if (sel < 75) begin
                    // plausible motion: +-90 deg, +-500 dps
                    ma = $urandom_range(11796480) - 5898240;
                    mr = $urandom_range(65536000) - 32768000;
                end else if (sel < 90) begin
                    ma = $urandom;
                    mr = $urandom;
                end else begin
                    ma = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
                    mr = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
                end
                send_sample(ma, mr, res);
            end
            in_valid <= 1'b0;
        end

        idle_mode = IDLE_NONE;
        while (estimate_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("sent %0d items over %0d register settings and four idle modes",
                 items_sent, N_PHASES + 1);
        $display("checked %0d results, %0d updates without gain, %0d mismatches",
                 results_seen, no_gain_steps, mismatches);
        if (mismatches == 0 && estimate_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("timeout with %0d items outstanding", estimate_q.size());
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: files.f
hdl/abkf_pkg.sv
hdl/abkf_arith.sv
hdl/angle_bias_kalman_filter.sv
dv/tb_angle_bias_kalman_filter.sv
